// ===== rtl/eucq_pkg.sv =====
// Shared types, fixed-point formats and constant tables for the Euler-to-quaternion block.
// Used by eucq_sincos and euler_deg_to_quaternion; depends on nothing else.
package eucq_pkg;

	// Port formats
	localparam int ANGLE_W         = 17;
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int QUAT_W          = 16;
	localparam int OUT_FRAC_BITS   = 14;

	// Axis lanes and output components
	localparam int NUM_AXES = 3;
	localparam int AX_YAW   = 0;
	localparam int AX_PITCH = 1;
	localparam int AX_ROLL  = 2;

	localparam int NUM_COMP = 4;
	localparam int QC_W     = 0;
	localparam int QC_X     = 1;
	localparam int QC_Y     = 2;
	localparam int QC_Z     = 3;

	// Pair products of the roll and pitch half angles
	localparam int NUM_PAIR = 4;
	localparam int PR_CRCP  = 0;
	localparam int PR_SRSP  = 1;
	localparam int PR_SRCP  = 2;
	localparam int PR_CRSP  = 3;

	// Half-angle phase: q = m * 2^(31-AFB) / 360 rounded, split as
	// m * 2^S = 45 * (m * HI) + m * LO, with S = 28 - AFB.
	localparam int PH_DIV    = 45;
	localparam int PH_SHIFT  = 28 - ANGLE_FRAC_BITS;
	localparam int PH_MUL_HI = (1 << PH_SHIFT) / PH_DIV;
	localparam int PH_MUL_LO = (1 << PH_SHIFT) % PH_DIV;
	localparam int PH_BIAS   = 22;
	localparam int HI_W      = 32;
	localparam int RES_W     = 23;
	localparam int RECIP_K   = 34;
	localparam int RECIP_W   = 30;
	localparam longint RECIP_M = ((64'sd1 <<< RECIP_K) + PH_DIV - 1) / PH_DIV;
	localparam int RPROD_W   = RES_W + RECIP_W;
	localparam int QUO_W     = RPROD_W - RECIP_K;
	localparam int PHASE_W   = 32;

	// CORDIC datapath, Q30 values and binary-turn angles
	localparam int CQ_W         = 32;
	localparam int CQ_FRAC      = 30;
	localparam int CORDIC_STEPS = 30;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [QUAT_W-1:0]  quat_t;
	typedef logic signed [CQ_W-1:0]    cq_t;

	localparam int PROD_W = 2 * CQ_W;
	typedef logic signed [PROD_W-1:0] prod_t;

	localparam cq_t CORDIC_GAIN = 32'sh26DD3B6A;

	localparam logic signed [PHASE_W:0] QUARTER_TURN = 33'sd1 <<< 30;
	localparam logic signed [PHASE_W:0] HALF_TURN    = 33'sd1 <<< 31;

	localparam cq_t ATAN_TURNS [CORDIC_STEPS] = '{
		32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
		32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
		32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
		32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
		32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
		32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
	};

	// Rounding constants
	localparam prod_t PAIR_HALF = 64'sd1 <<< (CQ_FRAC - 1);
	localparam int    FIN_SHIFT = 2 * CQ_FRAC - OUT_FRAC_BITS;
	localparam prod_t FIN_HALF  = 64'sd1 <<< (FIN_SHIFT - 1);
	localparam prod_t QLIM      = 64'sd1 <<< OUT_FRAC_BITS;

	// Q60 -> output format: round half up, saturate to +-1.0, keep the low bits
	function automatic quat_t quat_round(input prod_t v);
		prod_t r;
		r = (v + FIN_HALF) >>> FIN_SHIFT;
		if (r > QLIM)
			r = QLIM;
		else if (r < -QLIM)
			r = -QLIM;
		return QUAT_W'(r);
	endfunction

endpackage

// ===== rtl/eucq_sincos.sv =====
// Three-lane half-angle sine/cosine pipeline: phase scaling, quadrant fold,
// 30-stage unrolled CORDIC and sign fix. Depends on eucq_pkg.
module eucq_sincos import eucq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  angle_t angle [NUM_AXES],
	output logic   out_valid,
	output cq_t    sin_val [NUM_AXES],
	output cq_t    cos_val [NUM_AXES]
);

	// phase stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ANGLE_W-1:0] mag_s1 [NUM_AXES];
	logic               neg_s1 [NUM_AXES];
	logic [HI_W-1:0]    hi_s2  [NUM_AXES];
	logic [RES_W-1:0]   res_s2 [NUM_AXES];
	logic               neg_s2 [NUM_AXES];
	logic [HI_W-1:0]    hi_s3  [NUM_AXES];
	logic [QUO_W-1:0]   quo_s3 [NUM_AXES];
	logic               neg_s3 [NUM_AXES];
	logic [PHASE_W-1:0] q_s4   [NUM_AXES];
	logic               neg_s4 [NUM_AXES];
	cq_t                z_s5   [NUM_AXES];
	logic               flip_s5[NUM_AXES];

	logic [RPROD_W-1:0]        rprod [NUM_AXES];
	logic signed [PHASE_W:0]   zn    [NUM_AXES];
	logic signed [PHASE_W:0]   zr    [NUM_AXES];
	logic                      fl    [NUM_AXES];

	// CORDIC stages; index k holds the result of step k
	logic [CORDIC_STEPS-1:0] cv_s;
	cq_t  cx_s [NUM_AXES][CORDIC_STEPS];
	cq_t  cy_s [NUM_AXES][CORDIC_STEPS];
	cq_t  cz_s [NUM_AXES][CORDIC_STEPS];
	logic cf_s [NUM_AXES][CORDIC_STEPS];

	logic v_o;
	cq_t  sin_q [NUM_AXES];
	cq_t  cos_q [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			cv_s <= '0;
			v_o  <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			cv_s <= {cv_s[CORDIC_STEPS-2:0], v_s5};
			v_o  <= cv_s[CORDIC_STEPS-1];
		end
	end

	always_comb begin
		for (int l = 0; l < NUM_AXES; l++) begin
			rprod[l] = RPROD_W'(res_s2[l]) * RPROD_W'(RECIP_M);
			zn[l] = $signed({1'b0, q_s4[l]});
			if (neg_s4[l])
				zn[l] = -zn[l];
			// fold into +-90 degrees of half angle; sin and cos flip sign
			zr[l] = zn[l];
			fl[l] = 1'b0;
			if (zn[l] > QUARTER_TURN) begin
				zr[l] = zn[l] - HALF_TURN;
				fl[l] = 1'b1;
			end else if (zn[l] < -QUARTER_TURN) begin
				zr[l] = zn[l] + HALF_TURN;
				fl[l] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NUM_AXES; l++) begin
				mag_s1[l] <= angle[l][ANGLE_W-1] ? ANGLE_W'(-angle[l]) : ANGLE_W'(angle[l]);
				neg_s1[l] <= angle[l][ANGLE_W-1];

				hi_s2[l]  <= HI_W'(mag_s1[l]) * HI_W'(PH_MUL_HI);
				res_s2[l] <= RES_W'(mag_s1[l]) * RES_W'(PH_MUL_LO) + RES_W'(PH_BIAS);
				neg_s2[l] <= neg_s1[l];

				// residue / 45 by reciprocal, exact for residues below 2^30
				hi_s3[l]  <= hi_s2[l];
				quo_s3[l] <= rprod[l][RPROD_W-1:RECIP_K];
				neg_s3[l] <= neg_s2[l];

				q_s4[l]   <= hi_s3[l] + PHASE_W'(quo_s3[l]);
				neg_s4[l] <= neg_s3[l];

				z_s5[l]    <= CQ_W'(zr[l]);
				flip_s5[l] <= fl[l];

				sin_q[l] <= cf_s[l][CORDIC_STEPS-1] ? -cy_s[l][CORDIC_STEPS-1]
				                                    : cy_s[l][CORDIC_STEPS-1];
				cos_q[l] <= cf_s[l][CORDIC_STEPS-1] ? -cx_s[l][CORDIC_STEPS-1]
				                                    : cx_s[l][CORDIC_STEPS-1];
			end
		end
	end

	for (genvar l = 0; l < NUM_AXES; l++) begin : g_lane
		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
			cq_t  xi, yi, zi;
			logic fi;
			if (k == 0) begin : g_first
				assign xi = CORDIC_GAIN;
				assign yi = '0;
				assign zi = z_s5[l];
				assign fi = flip_s5[l];
			end else begin : g_next
				assign xi = cx_s[l][k-1];
				assign yi = cy_s[l][k-1];
				assign zi = cz_s[l][k-1];
				assign fi = cf_s[l][k-1];
			end

			always_ff @(posedge clk) begin
				if (en) begin
					if (!zi[CQ_W-1]) begin
						cx_s[l][k] <= xi - (yi >>> k);
						cy_s[l][k] <= yi + (xi >>> k);
						cz_s[l][k] <= zi - ATAN_TURNS[k];
					end else begin
						cx_s[l][k] <= xi + (yi >>> k);
						cy_s[l][k] <= yi - (xi >>> k);
						cz_s[l][k] <= zi + ATAN_TURNS[k];
					end
					cf_s[l][k] <= fi;
				end
			end
		end
	end

	assign out_valid = v_o;
	assign sin_val   = sin_q;
	assign cos_val   = cos_q;

	// folded phase must sit inside the CORDIC convergence range
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (z_s5[AX_YAW] <= CQ_W'(QUARTER_TURN)) && (z_s5[AX_YAW] >= -CQ_W'(QUARTER_TURN))
		      && (z_s5[AX_ROLL] <= CQ_W'(QUARTER_TURN)) && (z_s5[AX_ROLL] >= -CQ_W'(QUARTER_TURN)))
		else $error("folded phase out of range");

	// after the last step the pitch lane's residual angle is within +-64 LSBs
	a_converged: assert property (@(posedge clk) disable iff (!arst_n)
		cv_s[CORDIC_STEPS-1] |-> (cz_s[AX_PITCH][CORDIC_STEPS-1] <= 32'sd64)
		                      && (cz_s[AX_PITCH][CORDIC_STEPS-1] >= -32'sd64))
		else $error("CORDIC residual angle too large");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_o) && $stable(cv_s) && $stable(v_s5))
		else $error("valid bits moved during stall");

endmodule

// ===== rtl/euler_deg_to_quaternion.sv =====
// Top level: yaw/pitch/roll (degrees, fixed point) to Z-Y-X unit quaternion in Q2.14.
// Instantiates eucq_sincos; uses eucq_pkg.
//
// The block takes one attitude request per clock while the output side keeps up and
// returns one quaternion per request, in order. The pipeline is the 30-step unrolled
// CORDIC (one step per stage, three lanes side by side), five phase-scaling stages ahead
// of it, a sign-fix stage, and five stages for the two rounds of products, the sums and
// the rounding with clamp to +-1.0. The whole pipeline holds when the output stalls; a
// one-entry skid behind the output register keeps in_ready a plain register output.
// Angles outside +-180 degrees wrap; there is no state between requests and reset only
// clears the valid bits.
module euler_deg_to_quaternion import eucq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  angle_t yaw_angle,
	input  angle_t pitch_angle,
	input  angle_t roll_angle,
	output logic   out_valid,
	input  logic   out_ready,
	output quat_t  quat_w,
	output quat_t  quat_x,
	output quat_t  quat_y,
	output quat_t  quat_z
);

	logic   en;
	logic   push;
	angle_t angle_in [NUM_AXES];
	logic   cs_valid;
	cq_t    sin_v [NUM_AXES];
	cq_t    cos_v [NUM_AXES];

	logic  v_s1, v_s2, v_s3, v_s4;
	prod_t pp_s1   [NUM_PAIR];
	cq_t   cy_s1, sy_s1;
	cq_t   pair_s2 [NUM_PAIR];
	cq_t   cy_s2, sy_s2;
	prod_t tm_s3   [2*NUM_COMP];
	prod_t sum_s4  [NUM_COMP];
	quat_t fin     [NUM_COMP];

	logic  out_v_q, skid_v_q;
	quat_t out_q  [NUM_COMP];
	quat_t skid_q [NUM_COMP];

	assign en       = !skid_v_q;
	assign in_ready = en;
	assign push     = en && v_s4;

	assign angle_in[AX_YAW]   = yaw_angle;
	assign angle_in[AX_PITCH] = pitch_angle;
	assign angle_in[AX_ROLL]  = roll_angle;

	eucq_sincos u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.angle     (angle_in),
		.out_valid (cs_valid),
		.sin_val   (sin_v),
		.cos_val   (cos_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= cs_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// roll/pitch pair products, Q60
			pp_s1[PR_CRCP] <= PROD_W'(cos_v[AX_ROLL]) * PROD_W'(cos_v[AX_PITCH]);
			pp_s1[PR_SRSP] <= PROD_W'(sin_v[AX_ROLL]) * PROD_W'(sin_v[AX_PITCH]);
			pp_s1[PR_SRCP] <= PROD_W'(sin_v[AX_ROLL]) * PROD_W'(cos_v[AX_PITCH]);
			pp_s1[PR_CRSP] <= PROD_W'(cos_v[AX_ROLL]) * PROD_W'(sin_v[AX_PITCH]);
			cy_s1 <= cos_v[AX_YAW];
			sy_s1 <= sin_v[AX_YAW];

			for (int j = 0; j < NUM_PAIR; j++)
				pair_s2[j] <= CQ_W'((pp_s1[j] + PAIR_HALF) >>> CQ_FRAC);
			cy_s2 <= cy_s1;
			sy_s2 <= sy_s1;

			tm_s3[0] <= PROD_W'(pair_s2[PR_CRCP]) * PROD_W'(cy_s2);
			tm_s3[1] <= PROD_W'(pair_s2[PR_SRSP]) * PROD_W'(sy_s2);
			tm_s3[2] <= PROD_W'(pair_s2[PR_SRCP]) * PROD_W'(cy_s2);
			tm_s3[3] <= PROD_W'(pair_s2[PR_CRSP]) * PROD_W'(sy_s2);
			tm_s3[4] <= PROD_W'(pair_s2[PR_CRSP]) * PROD_W'(cy_s2);
			tm_s3[5] <= PROD_W'(pair_s2[PR_SRCP]) * PROD_W'(sy_s2);
			tm_s3[6] <= PROD_W'(pair_s2[PR_CRCP]) * PROD_W'(sy_s2);
			tm_s3[7] <= PROD_W'(pair_s2[PR_SRSP]) * PROD_W'(cy_s2);

			sum_s4[QC_W] <= tm_s3[0] + tm_s3[1];
			sum_s4[QC_X] <= tm_s3[2] - tm_s3[3];
			sum_s4[QC_Y] <= tm_s3[4] + tm_s3[5];
			sum_s4[QC_Z] <= tm_s3[6] - tm_s3[7];
		end
	end

	always_comb begin
		for (int c = 0; c < NUM_COMP; c++)
			fin[c] = quat_round(sum_s4[c]);
	end

	// output register plus one skid entry; the skid fills only in the cycle
	// the output stalls, and its fill stops the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || out_ready) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_ready) begin
			if (skid_v_q)
				out_q <= skid_q;
			else
				out_q <= fin;
		end else if (push) begin
			skid_q <= fin;
		end
	end

	assign out_valid = out_v_q;
	assign quat_w    = out_q[QC_W];
	assign quat_x    = out_q[QC_X];
	assign quat_y    = out_q[QC_Y];
	assign quat_z    = out_q[QC_Z];

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !out_ready && v_s4))
		else $error("skid filled without a stalled output");

	a_unit_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (quat_w <= QUAT_W'(QLIM)) && (quat_w >= -QUAT_W'(QLIM))
		         && (quat_x <= QUAT_W'(QLIM)) && (quat_x >= -QUAT_W'(QLIM))
		         && (quat_y <= QUAT_W'(QLIM)) && (quat_y >= -QUAT_W'(QLIM))
		         && (quat_z <= QUAT_W'(QLIM)) && (quat_z >= -QUAT_W'(QLIM)))
		else $error("quaternion component beyond unit range");

endmodule

// ===== tb/sv/euler_deg_to_quaternion_test.sv =====
// Testbench for euler_deg_to_quaternion: directed angle table, then random attitude requests.
// Depends on eucq_pkg (port types, format constants) and the euler_deg_to_quaternion RTL.
// Results are checked in order against typed rows or a bit-exact CORDIC and product model.
module euler_deg_to_quaternion_test import eucq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		quat_t w;
		quat_t x;
		quat_t y;
		quat_t z;
	} quat_rec_t;

	typedef struct {
		angle_t yaw;
		angle_t pitch;
		angle_t roll;
		bit     typed;
		quat_t  w;
		quat_t  x;
		quat_t  y;
		quat_t  z;
	} stim_row_t;

	localparam int     RANDOM_REQUESTS = 1700;
	localparam int     HALF_ANGLE_SH   = 31 - ANGLE_FRAC_BITS;
	localparam int     Q60_SHIFT       = 60 - OUT_FRAC_BITS;
	localparam longint SINCOS_GAIN     = 64'sd652032874;
	localparam longint QUARTER_PHASE   = 64'sd1073741824;
	localparam longint HALF_PHASE      = 64'sd2147483648;
	localparam longint UNIT_QUAT       = 64'sd1 <<< OUT_FRAC_BITS;
	localparam angle_t DEG180          = 46080;
	localparam angle_t DEG90           = 23040;

	// arctangent of 2^-i in binary turns (2^32 per turn)
	localparam longint ATAN_PHASE [30] = '{
		64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4, 64'sh028B0D43,
		64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55, 64'sh0028BE53, 64'sh00145F2F,
		64'sh000A2F98, 64'sh000517CC, 64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA,
		64'sh0000517D, 64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
		64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051, 64'sh00000029,
		64'sh00000014, 64'sh0000000A, 64'sh00000005, 64'sh00000003, 64'sh00000001
	};

	// Identity and poles (half angle +-90 deg) have typed results; other rows go to the model.
	localparam int N_DIRECTED = 24;
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{0,       0,       0,       1'b1, 16384,  0,      0,      0},
		'{DEG180,  0,       0,       1'b1, 0,      0,      0,      16384},
		'{-DEG180, 0,       0,       1'b1, 0,      0,      0,      -16384},
		'{0,       DEG180,  0,       1'b1, 0,      0,      16384,  0},
		'{0,       -DEG180, 0,       1'b1, 0,      0,      -16384, 0},
		'{0,       0,       DEG180,  1'b1, 0,      16384,  0,      0},
		'{0,       0,       -DEG180, 1'b1, 0,      -16384, 0,      0},
		'{DEG180,  DEG180,  DEG180,  1'b1, 16384,  0,      0,      0},
		'{-DEG180, -DEG180, -DEG180, 1'b1, -16384, 0,      0,      0},
		'{65535,   65535,   65535,   1'b0, 0, 0, 0, 0},
		'{-65536,  -65536,  -65536,  1'b0, 0, 0, 0, 0},
		'{65535,   -65536,  0,       1'b0, 0, 0, 0, 0},
		'{DEG90,   0,       0,       1'b0, 0, 0, 0, 0},
		'{0,       DEG90,   0,       1'b0, 0, 0, 0, 0},
		'{0,       0,       DEG90,   1'b0, 0, 0, 0, 0},
		'{1,       1,       1,       1'b0, 0, 0, 0, 0},
		'{-1,      -1,      -1,      1'b0, 0, 0, 0, 0},
		'{11520,   -11520,  34560,   1'b0, 0, 0, 0, 0},
		'{256,     512,     -768,    1'b0, 0, 0, 0, 0},
		'{46079,   -46079,  46079,   1'b0, 0, 0, 0, 0},
		'{46081,   -46081,  0,       1'b0, 0, 0, 0, 0},
		'{32768,   -32768,  16384,   1'b0, 0, 0, 0, 0},
		'{43690,   -21846,  21845,   1'b0, 0, 0, 0, 0},
		'{-DEG90,  DEG90,   -DEG90,  1'b0, 0, 0, 0, 0}
	};

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	angle_t yaw_angle = '0;
	angle_t pitch_angle = '0;
	angle_t roll_angle = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	quat_t  quat_w;
	quat_t  quat_x;
	quat_t  quat_y;
	quat_t  quat_z;

	quat_rec_t quats_awaited [$];
	int        mismatch_count = 0;
	int        sent_count = 0;

	euler_deg_to_quaternion dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.yaw_angle   (yaw_angle),
		.pitch_angle (pitch_angle),
		.roll_angle  (roll_angle),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.quat_w      (quat_w),
		.quat_x      (quat_x),
		.quat_y      (quat_y),
		.quat_z      (quat_z)
	);

	always #5 clk = ~clk;

	// Sine and cosine of half the angle, Q30, via 30-step rotation CORDIC.
	function automatic void half_angle_sincos(input angle_t ang, output longint s,
			output longint c);
		longint    num, mag, q, z, x, y, dx, dy;
		logic [31:0] ph;
		bit        flip;
		num = longint'(ang) * (64'sd1 <<< HALF_ANGLE_SH);
		mag = (num < 0) ? -num : num;
		q = (mag + 180) / 360;
		ph = 32'((num < 0) ? -q : q);
		z = longint'($signed(ph));
		flip = 1'b0;
		x = SINCOS_GAIN;
		y = 0;
		if (z > QUARTER_PHASE) begin
			z -= HALF_PHASE;
			flip = 1'b1;
		end else if (z < -QUARTER_PHASE) begin
			z += HALF_PHASE;
			flip = 1'b1;
		end
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_PHASE[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_PHASE[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint q30_product(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic quat_t round_clamp_q60(input longint q60);
		longint v;
		v = (q60 + (64'sd1 <<< (Q60_SHIFT - 1))) >>> Q60_SHIFT;
		if (v > UNIT_QUAT)
			v = UNIT_QUAT;
		if (v < -UNIT_QUAT)
			v = -UNIT_QUAT;
		return quat_t'(v);
	endfunction

	function automatic quat_rec_t zyx_quaternion(input angle_t yaw, input angle_t pitch,
			input angle_t roll);
		longint    sy, cy, sp, cp, sr, cr;
		longint    crcp, srsp, srcp, crsp;
		quat_rec_t q;
		half_angle_sincos(yaw, sy, cy);
		half_angle_sincos(pitch, sp, cp);
		half_angle_sincos(roll, sr, cr);
		crcp = q30_product(cr, cp);
		srsp = q30_product(sr, sp);
		srcp = q30_product(sr, cp);
		crsp = q30_product(cr, sp);
		q.w = round_clamp_q60(crcp * cy + srsp * sy);
		q.x = round_clamp_q60(srcp * cy - crsp * sy);
		q.y = round_clamp_q60(crsp * cy + srcp * sy);
		q.z = round_clamp_q60(crcp * sy - srsp * cy);
		return q;
	endfunction

	// every third stretch of 150 transfers runs with no idle cycles
	function automatic int idle_cycles(input int n);
		if ((n / 150) % 3 == 2)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	function automatic angle_t random_angle();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return angle_t'($urandom_range(0, 131071));
		if (pick < 8)
			return angle_t'(int'($urandom_range(0, 92160)) - 46080);
		// near a multiple of 90 deg, where the range fold and poles sit
		return angle_t'((int'($urandom_range(0, 4)) - 2) * 23040 +
			int'($urandom_range(0, 4)) - 2);
	endfunction

	task automatic send_request(input angle_t yaw, input angle_t pitch, input angle_t roll,
			input quat_rec_t want);
		int gap;
		gap = idle_cycles(sent_count);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		yaw_angle <= yaw;
		pitch_angle <= pitch;
		roll_angle <= roll;
		quats_awaited.insert(quats_awaited.size(), want);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
	endtask

	task automatic check_component(input string name, input quat_t want, input quat_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		quat_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (quats_awaited.size() == 0) begin
				$error("quaternion out with no request pending: w=%0d x=%0d y=%0d z=%0d",
					quat_w, quat_x, quat_y, quat_z);
				mismatch_count++;
			end else begin
				want = quats_awaited.pop_front();
				check_component("quat_w", want.w, quat_w);
				check_component("quat_x", want.x, quat_x);
				check_component("quat_y", want.y, quat_y);
				check_component("quat_z", want.z, quat_z);
			end
		end
	end

	// output-side backpressure
	initial begin : result_sink
		int gap;
		int taken;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = idle_cycles(taken);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		angle_t    y, p, r;
		quat_rec_t want;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].typed)
				want = '{directed_rows[i].w, directed_rows[i].x,
					directed_rows[i].y, directed_rows[i].z};
			else
				want = zyx_quaternion(directed_rows[i].yaw, directed_rows[i].pitch,
					directed_rows[i].roll);
			send_request(directed_rows[i].yaw, directed_rows[i].pitch,
				directed_rows[i].roll, want);
		end

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			y = random_angle();
			p = random_angle();
			r = random_angle();
			send_request(y, p, r, zyx_quaternion(y, p, r));
		end
		in_valid <= 1'b0;

		while (quats_awaited.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);

		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
